>>> sv/sfs_pkg.sv
// Shared constants and operation codes for the sprite frame sequencer.
// No dependencies; compiled first.
package sfs_pkg;

  localparam int OP_W           = 3;
  localparam int ELAPSED_W      = 16;
  localparam int DIR_IN_W       = 3;
  localparam int FRM_IN_W       = 3;
  localparam int DUR_IN_W       = 16;
  localparam int TILE_W         = 12;
  localparam int TIME_W         = 32;
  localparam int RESET_DURATION = 50;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_ACTIVATE  = 3'd2,
    OP_ENABLE    = 3'd3,
    OP_PAUSE     = 3'd4,
    OP_DISABLE   = 3'd5,
    OP_REPEAT    = 3'd6,
    OP_SET_FRAME = 3'd7
  } sfs_op_t;

endpackage

>>> sv/sfs_if.sv
// Valid/ready channel interfaces for the sprite frame sequencer.
// Depends on sfs_pkg for field widths.
interface sfs_in_if;
  logic                           valid;
  logic                           ready;
  logic [sfs_pkg::OP_W-1:0]       operation;
  logic [sfs_pkg::ELAPSED_W-1:0]  elapsed_ticks;
  logic [sfs_pkg::DIR_IN_W-1:0]   direction;
  logic [sfs_pkg::FRM_IN_W-1:0]   frame_index;
  logic [sfs_pkg::DUR_IN_W-1:0]   entry_duration;
  logic [sfs_pkg::TILE_W-1:0]     entry_tile;
  logic                           repeat_on;

  modport source (output valid, operation, elapsed_ticks, direction, frame_index,
                  entry_duration, entry_tile, repeat_on, input ready);
  modport sink (input valid, operation, elapsed_ticks, direction, frame_index,
                entry_duration, entry_tile, repeat_on, output ready);
endinterface

interface sfs_out_if;
  logic                           valid;
  logic                           ready;
  logic [sfs_pkg::TILE_W-1:0]     tile_index;
  logic [sfs_pkg::FRM_IN_W-1:0]   current_frame_out;
  logic [sfs_pkg::DIR_IN_W-1:0]   current_direction_out;
  logic                           animating_out;

  modport source (output valid, tile_index, current_frame_out, current_direction_out,
                  animating_out, input ready);
  modport sink (input valid, tile_index, current_frame_out, current_direction_out,
                animating_out, output ready);
endinterface

>>> sv/sfs_entry_ram.sv
// Frame entry RAM: one write port, one read port, registered read data.
// No dependencies.
module sfs_entry_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 28
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata_r
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

>>> sv/sprite_frame_sequencer.sv
// Sprite frame sequencer top: op decode, tick advance loop, output register.
// Each accepted word steps through EXEC, ADV for each frame a tick advances (max FPD),
// FIN, then OUT until the output register is free; the next word is taken only in IDLE.
// Reset: synchronous; a clear pass loads the entry RAM with default duration and tile
// before the first word is taken.
// Depends on sfs_pkg, sfs_if, sfs_entry_ram.
module sprite_frame_sequencer #(
  parameter int NUM_DIRECTIONS       = 8,
  parameter int FRAMES_PER_DIRECTION = 8,
  parameter int DURATION_WIDTH       = 16
) (
  input logic       clk,
  input logic       rst_n,
  sfs_in_if.sink    in_ch,
  sfs_out_if.source out_ch
);

  import sfs_pkg::*;

  localparam int DIR_W  = (NUM_DIRECTIONS > 1) ? $clog2(NUM_DIRECTIONS) : 1;
  localparam int FRM_W  = (FRAMES_PER_DIRECTION > 1) ? $clog2(FRAMES_PER_DIRECTION) : 1;
  localparam int CNT_W  = $clog2(FRAMES_PER_DIRECTION + 1);
  localparam int DEPTH  = NUM_DIRECTIONS * FRAMES_PER_DIRECTION;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = DURATION_WIDTH + TILE_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_ADV   = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [DIR_W-1:0] d,
                                                  input logic [FRM_W-1:0] f);
    return ADDR_W'(d) * ADDR_W'(FRAMES_PER_DIRECTION) + ADDR_W'(f);
  endfunction

  function automatic logic [FRM_W-1:0] next_frame(input logic [FRM_W-1:0] c,
                                                  input logic [CNT_W-1:0] fu,
                                                  input logic             rep);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(c) + CNT_W'(1);
    if (inc >= fu) begin
      return rep ? '0 : c;
    end
    return FRM_W'(inc);
  endfunction

  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0]    tl,
                                                input logic [ELAPSED_W-1:0] e);
    logic [TIME_W:0] d;
    d = {tl[TIME_W-1], tl} - (TIME_W+1)'(e);
    if (d[TIME_W] && !d[TIME_W-1]) begin
      return {1'b1, {(TIME_W-1){1'b0}}};
    end
    return d[TIME_W-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [DIR_W-1:0]  cur_dir_r, cur_dir_nxt;
  logic [FRM_W-1:0]  cur_frame_r, cur_frame_nxt;
  logic [FRM_W-1:0]  start_r, start_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  fu_cur_r, fu_cur_nxt;
  logic [TIME_W-1:0] tl_r, tl_nxt;
  logic              anim_r, anim_nxt;
  logic              rep_mode_r, rep_mode_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  fu_r [NUM_DIRECTIONS];

  sfs_op_t              op_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [DIR_IN_W-1:0]  dir_r;
  logic [FRM_IN_W-1:0]  frame_r;
  logic [DUR_IN_W-1:0]  dur_r;
  logic [TILE_W-1:0]    tile_r;
  logic                 rep_r;

  logic [TILE_W-1:0]   out_tile_r;
  logic [FRM_IN_W-1:0] out_frame_r;
  logic [DIR_IN_W-1:0] out_dir_r;
  logic                out_anim_r;

  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata, mem_rdata;
  logic [FRM_W-1:0]    rd_frame;
  logic [DURATION_WIDTH-1:0] rd_dur;
  logic [TILE_W-1:0]   rd_tile;

  logic                in_take, out_load;
  logic                dir_ok, frm_ok, fu_we;
  logic [DIR_W-1:0]    dsel;
  logic [CNT_W-1:0]    fu_sel, fu_wval;
  logic [FRM_W-1:0]    fe, base_frame, nx_setup, nx_adv;
  logic [TIME_W-1:0]   tl_sub, tl_add;

  sfs_entry_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  assign rd_dur  = mem_rdata[WORD_W-1 -: DURATION_WIDTH];
  assign rd_tile = mem_rdata[TILE_W-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.tile_index            = out_tile_r;
  assign out_ch.current_frame_out     = out_frame_r;
  assign out_ch.current_direction_out = out_dir_r;
  assign out_ch.animating_out         = out_anim_r;

  assign dir_ok     = int'(dir_r) < NUM_DIRECTIONS;
  assign frm_ok     = int'(frame_r) < FRAMES_PER_DIRECTION;
  assign dsel       = dir_ok ? DIR_W'(dir_r) : '0;
  assign fu_sel     = fu_r[dsel];
  assign fe         = FRM_W'(frame_r);
  assign fu_wval    = CNT_W'(fe) + CNT_W'(1);
  assign fu_we      = (state_r == S_EXEC) && (op_r == OP_WRITE) && dir_ok && frm_ok &&
                      (CNT_W'(fe) >= fu_sel);
  assign base_frame = (op_r == OP_DISABLE) ? '0 : cur_frame_r;
  assign tl_sub     = sat_sub(tl_r, (op_r == OP_DISABLE) ? '0 : elapsed_r);
  assign nx_setup   = next_frame(base_frame, fu_cur_r, rep_mode_r);
  assign tl_add     = tl_r + TIME_W'(rd_dur);
  assign nx_adv     = next_frame(cur_frame_r, fu_cur_r, rep_mode_r);
  assign mem_raddr  = slot_addr(cur_dir_r, rd_frame);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_dir_nxt   = cur_dir_r;
    cur_frame_nxt = cur_frame_r;
    start_nxt     = start_r;
    n_nxt         = n_r;
    fu_cur_nxt    = fu_cur_r;
    tl_nxt        = tl_r;
    anim_nxt      = anim_r;
    rep_mode_nxt  = rep_mode_r;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_r;
    mem_wdata     = {DURATION_WIDTH'(RESET_DURATION), TILE_W'(0)};
    mem_re        = 1'b0;
    rd_frame      = cur_frame_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (op_r) inside
          OP_TICK, OP_DISABLE: begin
            start_nxt = base_frame;
            if (op_r == OP_DISABLE) begin
              cur_frame_nxt = '0;
            end
            if (anim_r) begin
              tl_nxt = tl_sub;
              if (tl_sub[TIME_W-1]) begin
                cur_frame_nxt = nx_setup;
                if (nx_setup != base_frame) begin
                  mem_re    = 1'b1;
                  rd_frame  = nx_setup;
                  n_nxt     = CNT_W'(1);
                  state_nxt = S_ADV;
                end
              end
            end
          end
          OP_WRITE: begin
            if (dir_ok && frm_ok) begin
              mem_we    = 1'b1;
              mem_waddr = slot_addr(dsel, fe);
              mem_wdata = {DURATION_WIDTH'(dur_r), tile_r};
              if (fu_we && (dsel == cur_dir_r)) begin
                fu_cur_nxt = fu_wval;
              end
            end
          end
          OP_ACTIVATE: begin
            if (CNT_W'(cur_frame_r) >= fu_sel) begin
              cur_frame_nxt = '0;
            end
            cur_dir_nxt  = dsel;
            fu_cur_nxt   = fu_sel;
            rep_mode_nxt = 1'b1;
          end
          OP_ENABLE: begin
          end
          OP_PAUSE: begin
            anim_nxt = 1'b0;
          end
          OP_REPEAT: begin
            rep_mode_nxt = rep_r;
          end
          OP_SET_FRAME: begin
            cur_frame_nxt = (int'(frame_r) < int'(fu_cur_r)) ? fe : '0;
            rep_mode_nxt  = 1'b1;
          end
        endcase
      end
      S_ADV: begin
        tl_nxt    = tl_add;
        state_nxt = S_FIN;
        if ((n_r < CNT_W'(FRAMES_PER_DIRECTION)) && tl_add[TIME_W-1]) begin
          cur_frame_nxt = nx_adv;
          if (nx_adv != start_r) begin
            mem_re    = 1'b1;
            rd_frame  = nx_adv;
            n_nxt     = n_r + CNT_W'(1);
            state_nxt = S_ADV;
          end
        end
      end
      S_FIN: begin
        mem_re    = 1'b1;
        state_nxt = S_OUT;
        if (op_r == OP_DISABLE) begin
          anim_nxt = 1'b0;
        end
      end
      S_OUT: begin
        if ((op_r == OP_ENABLE) && !anim_r) begin
          anim_nxt = 1'b1;
          tl_nxt   = TIME_W'(rd_dur);
        end
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cur_dir_r   <= '0;
      cur_frame_r <= '0;
      start_r     <= '0;
      n_r         <= '0;
      fu_cur_r    <= '0;
      tl_r        <= '0;
      anim_r      <= 1'b0;
      rep_mode_r  <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_DIRECTIONS; i++) begin
        fu_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cur_dir_r   <= cur_dir_nxt;
      cur_frame_r <= cur_frame_nxt;
      start_r     <= start_nxt;
      n_r         <= n_nxt;
      fu_cur_r    <= fu_cur_nxt;
      tl_r        <= tl_nxt;
      anim_r      <= anim_nxt;
      rep_mode_r  <= rep_mode_nxt;
      out_valid_r <= out_valid_nxt;
      if (fu_we) begin
        fu_r[dsel] <= fu_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r      <= sfs_op_t'(in_ch.operation);
      elapsed_r <= in_ch.elapsed_ticks;
      dir_r     <= in_ch.direction;
      frame_r   <= in_ch.frame_index;
      dur_r     <= in_ch.entry_duration;
      tile_r    <= in_ch.entry_tile;
      rep_r     <= in_ch.repeat_on;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tile_r  <= rd_tile;
      out_frame_r <= FRM_IN_W'(cur_frame_r);
      out_dir_r   <= DIR_IN_W'(cur_dir_r);
      out_anim_r  <= (op_r == OP_ENABLE) ? 1'b1 : anim_r;
    end
  end

  a_fu_cur_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (fu_cur_r == fu_r[cur_dir_r]))
    else $error("cached frame count differs from table");

  a_lap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV) |-> ((n_r != '0) && (n_r <= CNT_W'(FRAMES_PER_DIRECTION))))
    else $error("advance count out of range");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && (!out_valid_r || out_ch.ready)) |=>
    (out_valid_r && (state_r == S_IDLE)))
    else $error("result word not presented");

  a_disable_stops: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && (op_r == OP_DISABLE)) |=> !anim_r)
    else $error("animation still on after disable");

  a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_CLEAR) || ((state_r == S_EXEC) && (op_r == OP_WRITE))))
    else $error("unexpected entry RAM write");

endmodule
